[src/lsbx_pkg.sv]
// Package for the bitmap LSB character extractor.
// Holds the item type, the result kind codes and the header byte positions.
// No dependencies.
package lsbx_pkg;

  // One raw file byte with its restart marker.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_req;
  } lsbx_item_t;

  // Result kinds reported on the output channel.
  typedef enum logic [2:0] {
    KIND_CHAR       = 3'd0,
    KIND_NOT_BMP    = 3'd1,
    KIND_BAD_OFFSET = 3'd2,
    KIND_BAD_BPP    = 3'd3,
    KIND_ZERO       = 3'd4,
    KIND_EXHAUSTED  = 3'd5
  } lsbx_kind_t;

  // Header layout; position HDR_LEN means the pixel payload phase.
  localparam logic [5:0] HDR_LEN  = 6'd54;
  localparam logic [5:0] POS_SIG0 = 6'd0;
  localparam logic [5:0] POS_SIG1 = 6'd1;
  localparam logic [5:0] POS_OFF0 = 6'd10;
  localparam logic [5:0] POS_OFF3 = 6'd13;
  localparam logic [5:0] POS_WID0 = 6'd18;
  localparam logic [5:0] POS_WID3 = 6'd21;
  localparam logic [5:0] POS_HGT0 = 6'd22;
  localparam logic [5:0] POS_HGT3 = 6'd25;
  localparam logic [5:0] POS_ROW  = 6'd26;
  localparam logic [5:0] POS_PLO  = 6'd27;
  localparam logic [5:0] POS_DEP0 = 6'd28;
  localparam logic [5:0] POS_DEP1 = 6'd29;
  localparam logic [5:0] POS_LAST = 6'd53;

  localparam logic [7:0]  SIG_FIRST  = 8'h42;
  localparam logic [7:0]  SIG_SECOND = 8'h4D;
  localparam logic [31:0] WANT_OFFSET = 32'd54;
  localparam logic [7:0]  WANT_BPP   = 8'd24;
  localparam logic [1:0]  LAST_PHASE = 2'd3;

endpackage

[src/lsbx_if.sv]
// Valid/ready channel interfaces for the bitmap LSB character extractor.
// Depends on lsbx_pkg only through the widths it mirrors.
interface lsbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_req;

  modport source (output valid, output file_byte, output start_req, input ready);
  modport sink   (input valid, input file_byte, input start_req, output ready);
endinterface

interface lsbx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       finished;

  modport source (output valid, output kind, output value, output finished, input ready);
  modport sink   (input valid, input kind, input value, input finished, output ready);
endinterface

[src/lsbx_in_stage.sv]
// Input register stage of the bitmap LSB character extractor.
// Depends on lsbx_pkg for the item type.
module lsbx_in_stage
  import lsbx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  lsbx_item_t up_item,
  output logic       dn_valid,
  input  logic       dn_ready,
  output lsbx_item_t dn_item
);

  logic       valid_r;
  lsbx_item_t item_r;

  // The stage takes a new byte when empty or when its content moves on.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload register, loaded on every transfer.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

[src/lsbx_decode.sv]
// Header parser, payload length unit, bit packer and result register.
// Depends on lsbx_pkg for the item type, kind codes and header positions.
module lsbx_decode
  import lsbx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  output logic       item_ready,
  input  lsbx_item_t item,
  output logic       res_valid,
  input  logic       res_ready,
  output lsbx_kind_t res_kind,
  output logic [7:0] res_value,
  output logic       res_finished
);

  // Control state.
  logic [5:0]  pos_r, pos_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  // Header and payload registers.
  logic        sig_ok_r, sig_ok_nxt;
  logic [23:0] off_r, off_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [33:0] row_r, row_nxt;
  logic [49:0] plo_r, plo_nxt;
  logic [48:0] phi_r, phi_nxt;
  logic [63:0] total_r, total_nxt;
  logic [61:0] quads_r, quads_nxt;
  logic [5:0]  gather_r, gather_nxt;
  lsbx_kind_t  kind_r, kind_nxt;
  logic [7:0]  value_r, value_nxt;
  logic        fin_r, fin_nxt;

  logic        fire;
  logic        start;
  logic [7:0]  b;
  logic [5:0]  pos_c;
  logic        done_c;
  logic [1:0]  phase_c;
  logic [1:0]  lane;
  logic [7:0]  ch;
  logic        wpos;
  logic        hpos;
  logic [33:0] w3;
  logic [15:0] mul_b;
  logic [49:0] prod;

  // A byte is processed when the result register is free to take its outcome.
  assign item_ready = !out_valid_r || res_ready;
  assign fire       = item_valid && item_ready;
  assign start      = item.start_req;
  assign b          = item.file_byte;

  assign res_valid    = out_valid_r;
  assign res_kind     = kind_r;
  assign res_value    = value_r;
  assign res_finished = fin_r;

  // Payload length datapath: row size, then one shared 34x16 multiplier
  // used for the low and the high half of the height on two header bytes.
  assign wpos  = (width_r != 32'd0) && !width_r[31];
  assign hpos  = (height_r != 32'd0) && !height_r[31];
  assign w3    = {3'b000, width_r[30:0]} + {2'b00, width_r[30:0], 1'b0} + 34'd3;
  assign mul_b = (pos_c == POS_PLO) ? height_r[15:0] : {1'b0, height_r[30:16]};
  assign prod  = row_r * mul_b;
  assign ch    = {gather_r, b[1:0]};

  always_comb begin
    pos_c   = start ? 6'd0 : pos_r;
    done_c  = start ? 1'b0 : done_r;
    phase_c = start ? 2'd0 : phase_r;
    lane    = 2'd0;

    pos_nxt    = pos_r;
    done_nxt   = done_r;
    phase_nxt  = phase_r;
    sig_ok_nxt = sig_ok_r;
    off_nxt    = off_r;
    depth_nxt  = depth_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    total_nxt  = total_r;
    quads_nxt  = quads_r;
    gather_nxt = gather_r;

    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    fin_nxt       = fin_r;

    // The result register empties once its transfer is done.
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      pos_nxt       = pos_c;
      done_nxt      = done_c;
      phase_nxt     = phase_c;
      out_valid_nxt = 1'b0;
      kind_nxt      = KIND_CHAR;
      value_nxt     = 8'd0;
      fin_nxt       = 1'b0;

      if (!done_c) begin
        if (pos_c < HDR_LEN) begin
          // Header byte: capture fields and check the three warnings.
          pos_nxt = pos_c + 6'd1;
          if (pos_c == POS_SIG0) begin
            sig_ok_nxt = (b == SIG_FIRST);
          end else if (pos_c == POS_SIG1) begin
            if (!(sig_ok_r && b == SIG_SECOND)) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_NOT_BMP;
            end
          end else if (pos_c >= POS_OFF0 && pos_c < POS_OFF3) begin
            lane = 2'(pos_c - POS_OFF0);
            off_nxt[lane*8 +: 8] = b;
          end else if (pos_c == POS_OFF3) begin
            if ({b, off_r} != WANT_OFFSET) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_BAD_OFFSET;
            end
          end else if (pos_c >= POS_WID0 && pos_c <= POS_WID3) begin
            lane = 2'(pos_c - POS_WID0);
            width_nxt[lane*8 +: 8] = b;
          end else if (pos_c >= POS_HGT0 && pos_c <= POS_HGT3) begin
            lane = 2'(pos_c - POS_HGT0);
            height_nxt[lane*8 +: 8] = b;
          end else if (pos_c == POS_ROW) begin
            row_nxt = w3 & ~34'd3;
          end else if (pos_c == POS_PLO) begin
            plo_nxt = prod;
          end else if (pos_c == POS_DEP0) begin
            depth_nxt = b;
            phi_nxt   = prod[48:0];
          end else if (pos_c == POS_DEP1) begin
            total_nxt = {14'd0, plo_r} + {phi_r[47:0], 16'd0};
            if (!(depth_r == WANT_BPP && b == 8'd0)) begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_BAD_BPP;
            end
          end else if (pos_c == POS_LAST) begin
            // A zero or negative dimension leaves no payload at all.
            if (wpos && hpos) begin
              quads_nxt = total_r[63:2];
            end else begin
              out_valid_nxt = 1'b1;
              kind_nxt      = KIND_EXHAUSTED;
              fin_nxt       = 1'b1;
              done_nxt      = 1'b1;
            end
          end
        end else if (phase_c != LAST_PHASE) begin
          // Payload byte: collect its two low bits.
          gather_nxt = {gather_r[3:0], b[1:0]};
          phase_nxt  = phase_c + 2'd1;
        end else begin
          // Fourth payload byte completes a character.
          phase_nxt     = 2'd0;
          quads_nxt     = quads_r - 62'd1;
          out_valid_nxt = 1'b1;
          if (ch == 8'd0) begin
            kind_nxt = KIND_ZERO;
            fin_nxt  = 1'b1;
            done_nxt = 1'b1;
          end else begin
            value_nxt = ch;
            if (quads_r == 62'd1) begin
              fin_nxt  = 1'b1;
              done_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 6'd0;
      done_r      <= 1'b0;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Header fields, length datapath and result payload.
  always_ff @(posedge clk) begin
    sig_ok_r <= sig_ok_nxt;
    off_r    <= off_nxt;
    depth_r  <= depth_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    row_r    <= row_nxt;
    plo_r    <= plo_nxt;
    phi_r    <= phi_nxt;
    total_r  <= total_nxt;
    quads_r  <= quads_nxt;
    gather_r <= gather_nxt;
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    fin_r    <= fin_nxt;
  end

endmodule

[src/bmp_lsb_stego_extractor_unit.sv]
// Bitmap LSB character extractor, top level.
// A byte passes the input register, then its outcome is held in the result register.
// Throughput: one byte per cycle unless a result waits on out_chan.ready; set by the register pair.
// Payload length is built over header bytes 26 to 29 on one shared 34x16 multiplier.
// Reset (rst_n low, synchronous) empties both stages; the first byte after it is header byte 0.
// Depends on lsbx_pkg, lsbx_if, lsbx_in_stage and lsbx_decode.
module bmp_lsb_stego_extractor_unit
  import lsbx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lsbx_in_if.sink     in_chan,
  lsbx_out_if.source  out_chan
);

  lsbx_item_t up_item;
  lsbx_item_t st_item;
  logic       st_valid;
  logic       st_ready;
  lsbx_kind_t kind;

  assign up_item.file_byte = in_chan.file_byte;
  assign up_item.start_req = in_chan.start_req;

  // Input register.
  lsbx_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_item  (up_item),
    .dn_valid (st_valid),
    .dn_ready (st_ready),
    .dn_item  (st_item)
  );

  // Parser, packer and result register.
  lsbx_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (st_valid),
    .item_ready   (st_ready),
    .item         (st_item),
    .res_valid    (out_chan.valid),
    .res_ready    (out_chan.ready),
    .res_kind     (kind),
    .res_value    (out_chan.value),
    .res_finished (out_chan.finished)
  );

  assign out_chan.kind = kind;

endmodule
